### hw/rtl/sha1sh_pkg.sv
// ----------------------------------------------------------------------------
// sha1sh_pkg
// Constants and helpers for the streaming SHA-1 hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1sh_pkg;

    localparam int unsigned WordW  = 32;
    localparam int unsigned CountW = 61;
    localparam int unsigned Rounds = 80;

    localparam logic [WordW-1:0] H0 = 32'h6745_2301;
    localparam logic [WordW-1:0] H1 = 32'hEFCD_AB89;
    localparam logic [WordW-1:0] H2 = 32'h98BA_DCFE;
    localparam logic [WordW-1:0] H3 = 32'h1032_5476;
    localparam logic [WordW-1:0] H4 = 32'hC3D2_E1F0;

    localparam logic [WordW-1:0] K0 = 32'h5A82_7999;
    localparam logic [WordW-1:0] K1 = 32'h6ED9_EBA1;
    localparam logic [WordW-1:0] K2 = 32'h8F1B_BCDC;
    localparam logic [WordW-1:0] K3 = 32'hCA62_C1D6;

    localparam logic [7:0] PadByte = 8'h80;

    typedef logic [4:0][WordW-1:0]  t_chain;
    typedef logic [15:0][WordW-1:0] t_sched;

    localparam t_chain InitChain = {H4, H3, H2, H1, H0};

    function automatic logic [WordW-1:0] rotl1(input logic [WordW-1:0] x);
        return {x[WordW-2:0], x[WordW-1]};
    endfunction

    function automatic logic [WordW-1:0] rotl5(input logic [WordW-1:0] x);
        return {x[WordW-6:0], x[WordW-1:WordW-5]};
    endfunction

    function automatic logic [WordW-1:0] rotl30(input logic [WordW-1:0] x);
        return {x[1:0], x[WordW-1:2]};
    endfunction

endpackage

`default_nettype wire

### hw/rtl/sha1_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha1_stream_hasher
// Streaming SHA-1: one message byte per request, digest after the last request.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready): each request carries a byte, a
// has-byte flag and a last flag. A last request with no byte ends the message
// without adding one, so an empty message is legal.
// Output channel (o_out_valid / i_out_ready): one request per message with the
// five digest words, word0 most significant.
// Bytes are taken one per cycle while a block fills. The 64th byte of a block
// starts the compression: one shared round unit runs 80 rounds, one per cycle,
// then the ADD state adds the result into the chaining words; the input is not
// ready until that is done, so no byte is taken while a block compresses.
// After the last request the padding is written one word per cycle and one
// or two compressions run: two when the length spills into a second block or
// when the last byte fills a block, which is compressed before its padding.
// Then DONE loads the digest register once the output register is free.
// The digest register decouples the sides: a new message is accepted while a
// digest waits; only the next digest waits for the receiver to take it.
// Reset (synchronous, active low) restores the initial chaining values, a
// zero byte count and an empty output.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_stream_hasher (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output      logic        o_in_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_has_byte,
    input  wire logic        i_last,
    output      logic        o_out_valid,
    input  wire logic        i_out_ready,
    output      logic [31:0] o_digest_word0,
    output      logic [31:0] o_digest_word1,
    output      logic [31:0] o_digest_word2,
    output      logic [31:0] o_digest_word3,
    output      logic [31:0] o_digest_word4
);
    import sha1sh_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD_BYTE,
        ST_FILL,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        AFT_IDLE,
        AFT_PAD,
        AFT_FILL,
        AFT_OUT
    } t_after;

    t_state              r_state, n_state;
    t_after              r_after, n_after;
    t_chain              r_chain, n_chain;
    t_chain              r_vars, n_vars;
    t_chain              r_digest, n_digest;
    t_sched              r_sched, n_sched;
    logic [WordW-1:0]    r_acc, n_acc;
    logic [CountW-1:0]   r_count, n_count;
    logic [6:0]          r_round, n_round;
    logic [3:0]          r_wpos, n_wpos;
    logic                r_len_here, n_len_here;
    logic                r_out_valid, n_out_valid;

    logic                in_acc;
    logic [5:0]          pos;
    logic [4:0]          byte_sh;
    logic [WordW-1:0]    byte_word;
    logic [WordW-1:0]    pad_word;
    logic [WordW-1:0]    acc_next;
    logic [63:0]         bit_len;
    logic [WordW-1:0]    fill_word;
    logic [WordW-1:0]    f_val;
    logic [WordW-1:0]    k_val;
    logic [WordW-1:0]    t_val;
    logic [WordW-1:0]    sched_new;

    assign o_in_ready     = (r_state == ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_digest_word0 = r_digest[0];
    assign o_digest_word1 = r_digest[1];
    assign o_digest_word2 = r_digest[2];
    assign o_digest_word3 = r_digest[3];
    assign o_digest_word4 = r_digest[4];

    assign in_acc    = i_in_valid && o_in_ready;
    assign pos       = r_count[5:0];
    assign byte_sh   = {pos[1:0], 3'b000};
    assign byte_word = {i_data_byte, 24'h00_0000} >> byte_sh;
    assign pad_word  = (pos[1:0] == 2'd0) ? ({PadByte, 24'h00_0000} >> byte_sh)
                                          : (r_acc | ({PadByte, 24'h00_0000} >> byte_sh));
    assign acc_next  = (pos[1:0] == 2'd0) ? byte_word : (r_acc | byte_word);
    assign bit_len   = {r_count, 3'b000};

    always_comb begin
        if (r_len_here && r_wpos == 4'd14) begin
            fill_word = bit_len[63:32];
        end else if (r_len_here && r_wpos == 4'd15) begin
            fill_word = bit_len[31:0];
        end else begin
            fill_word = '0;
        end
    end

    // Shared round unit: b = vars[1], c = vars[2], d = vars[3].
    always_comb begin
        if (r_round < 7'd20) begin
            f_val = (r_vars[1] & r_vars[2]) | (~r_vars[1] & r_vars[3]);
            k_val = K0;
        end else if (r_round < 7'd40) begin
            f_val = r_vars[1] ^ r_vars[2] ^ r_vars[3];
            k_val = K1;
        end else if (r_round < 7'd60) begin
            f_val = (r_vars[1] & r_vars[2]) | (r_vars[1] & r_vars[3]) |
                    (r_vars[2] & r_vars[3]);
            k_val = K2;
        end else begin
            f_val = r_vars[1] ^ r_vars[2] ^ r_vars[3];
            k_val = K3;
        end
    end

    assign t_val     = rotl5(r_vars[0]) + f_val + r_vars[4] + k_val + r_sched[0];
    // The schedule slides one word per round; slot 0 always holds this round's word.
    assign sched_new = rotl1(r_sched[13] ^ r_sched[8] ^ r_sched[2] ^ r_sched[0]);

    always_comb begin
        n_state     = r_state;
        n_after     = r_after;
        n_chain     = r_chain;
        n_vars      = r_vars;
        n_digest    = r_digest;
        n_sched     = r_sched;
        n_acc       = r_acc;
        n_count     = r_count;
        n_round     = r_round;
        n_wpos      = r_wpos;
        n_len_here  = r_len_here;
        n_out_valid = r_out_valid;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_acc && i_has_byte) begin
                    n_acc   = acc_next;
                    n_count = r_count + {{(CountW-1){1'b0}}, 1'b1};
                    if (pos[1:0] == 2'd3) begin
                        n_sched = {acc_next, r_sched[15:1]};
                    end
                    if (pos == 6'd63) begin
                        n_vars  = r_chain;
                        n_round = '0;
                        n_state = ST_ROUND;
                        n_after = i_last ? AFT_PAD : AFT_IDLE;
                    end else if (i_last) begin
                        n_state = ST_PAD_BYTE;
                    end
                end else if (in_acc && i_last) begin
                    n_state = ST_PAD_BYTE;
                end
            end
            ST_PAD_BYTE: begin
                n_sched    = {pad_word, r_sched[15:1]};
                n_wpos     = pos[5:2] + 4'd1;
                n_len_here = (pos[5:3] != 3'b111);
                if (pos[5:2] == 4'd15) begin
                    n_vars  = r_chain;
                    n_round = '0;
                    n_state = ST_ROUND;
                    n_after = AFT_FILL;
                end else begin
                    n_state = ST_FILL;
                end
            end
            ST_FILL: begin
                n_sched = {fill_word, r_sched[15:1]};
                n_wpos  = r_wpos + 4'd1;
                if (r_wpos == 4'd15) begin
                    n_vars  = r_chain;
                    n_round = '0;
                    n_state = ST_ROUND;
                    n_after = r_len_here ? AFT_OUT : AFT_FILL;
                end
            end
            ST_ROUND: begin
                n_vars[4] = r_vars[3];
                n_vars[3] = r_vars[2];
                n_vars[2] = rotl30(r_vars[1]);
                n_vars[1] = r_vars[0];
                n_vars[0] = t_val;
                n_sched   = {sched_new, r_sched[15:1]};
                if (r_round == 7'(Rounds - 1)) begin
                    n_round = '0;
                    n_state = ST_ADD;
                end else begin
                    n_round = r_round + 7'd1;
                end
            end
            ST_ADD: begin
                for (int i = 0; i < 5; i++) begin
                    n_chain[i] = r_chain[i] + r_vars[i];
                end
                case (r_after)
                    AFT_IDLE: n_state = ST_IDLE;
                    AFT_PAD:  n_state = ST_PAD_BYTE;
                    AFT_FILL: begin
                        // The length goes into this second, otherwise zero block.
                        n_state    = ST_FILL;
                        n_wpos     = '0;
                        n_len_here = 1'b1;
                    end
                    AFT_OUT:  n_state = ST_DONE;
                    default:  n_state = ST_IDLE;
                endcase
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_digest    = r_chain;
                    n_out_valid = 1'b1;
                    n_chain     = InitChain;
                    n_count     = '0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_after     <= AFT_IDLE;
            r_chain     <= InitChain;
            r_vars      <= '0;
            r_count     <= '0;
            r_round     <= '0;
            r_wpos      <= '0;
            r_len_here  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_after     <= n_after;
            r_chain     <= n_chain;
            r_vars      <= n_vars;
            r_count     <= n_count;
            r_round     <= n_round;
            r_wpos      <= n_wpos;
            r_len_here  <= n_len_here;
            r_out_valid <= n_out_valid;
        end
        r_digest <= n_digest;
        r_sched  <= n_sched;
        r_acc    <= n_acc;
    end

`ifndef ASSERT_OFF
    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_round < 7'(Rounds))
        else $error("round counter out of range");

    a_round_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND && $past(r_state) != ST_ROUND) |-> r_round == 7'd0)
        else $error("compression started at a nonzero round");

    a_digest_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> (r_count == '0 && r_chain == InitChain))
        else $error("digest issued without restarting the chain");
`endif

endmodule

`default_nettype wire

### tb/sha1_stream_hasher_tb.sv
// ----------------------------------------------------------------------------
// sha1_stream_hasher_tb
// Self-checking bench for the streaming SHA-1 hasher. Messages go in one byte
// per request. A behavioral SHA-1 built from the padding and compression
// rules computes each digest as the last request is accepted. Returned
// digests are checked in order against those predictions. The stimulus
// covers directed vectors, block and padding boundaries, random traffic
// under several idle mixes, and a long output stall that backs up the input.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_stream_hasher_tb;

    import sha1sh_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned TAIL_CYCLES  = 200;
    localparam int unsigned PHASE_ITEMS  = 215;
    localparam int unsigned HOLDOFF_LEN  = 2000;
    localparam int unsigned MAX_REPORTS  = 10;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic [7:0]  i_data_byte   = 8'h00;
    logic        i_has_byte    = 1'b0;
    logic        i_last        = 1'b0;
    logic        i_out_ready   = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [31:0] o_digest_word0;
    logic [31:0] o_digest_word1;
    logic [31:0] o_digest_word2;
    logic [31:0] o_digest_word3;
    logic [31:0] o_digest_word4;

    // Predicted hash state, kept in step with the accepted requests.
    t_chain      hash_chain = InitChain;
    t_sched      blk_words  = '0;
    logic [60:0] msg_len    = '0;
    t_chain      digest_q[$];

    int unsigned err_cnt       = 0;
    int unsigned items_sent    = 0;
    int unsigned cycle_cnt     = 0;
    int unsigned snd_idle_pct  = 0;
    int unsigned rcv_stall_pct = 0;
    logic        holdoff_on    = 1'b0;

    t_chain      got_digest;
    t_chain      want_digest;
    int          chk_idx;

    sha1_stream_hasher u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_data_byte    (i_data_byte),
        .i_has_byte     (i_has_byte),
        .i_last         (i_last),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_digest_word0 (o_digest_word0),
        .o_digest_word1 (o_digest_word1),
        .o_digest_word2 (o_digest_word2),
        .o_digest_word3 (o_digest_word3),
        .o_digest_word4 (o_digest_word4)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Behavioral SHA-1
    // ------------------------------------------------------------------
    function automatic logic [31:0] rol32(logic [31:0] x, int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic t_chain sha1_compress(t_chain h, t_sched w_in);
        t_sched      w;
        logic [31:0] a, b, c, d, e, f, k, wt, sum;
        int          r;
        w = w_in;
        a = h[0];
        b = h[1];
        c = h[2];
        d = h[3];
        e = h[4];
        for (r = 0; r < 80; r++) begin
            if (r < 16) begin
                wt = w[r];
            end else begin
                wt = rol32(w[(r - 3) & 15] ^ w[(r - 8) & 15] ^ w[(r - 14) & 15] ^ w[r & 15], 1);
                w[r & 15] = wt;
            end
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = K0;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = K1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K2;
            end else begin
                f = b ^ c ^ d;
                k = K3;
            end
            sum = rol32(a, 5) + f + e + k + wt;
            e = d;
            d = c;
            c = rol32(b, 30);
            b = a;
            a = sum;
        end
        return {h[4] + e, h[3] + d, h[2] + c, h[1] + b, h[0] + a};
    endfunction

    // The first byte of a word clears the rest of it.
    function automatic void put_msg_byte(logic [5:0] pos, logic [7:0] data);
        int sh;
        sh = 8 * (3 - int'(pos[1:0]));
        if (pos[1:0] == 2'd0) begin
            blk_words[pos[5:2]] = {data, 24'h0};
        end else begin
            blk_words[pos[5:2]][sh +: 8] = data;
        end
    endfunction

    function automatic void sha1_absorb(logic [7:0] data, logic has, logic fin);
        logic [5:0]  pos;
        logic [63:0] bit_len;
        int          wi;
        if (has) begin
            pos = msg_len[5:0];
            put_msg_byte(pos, data);
            msg_len = msg_len + 61'd1;
            if (pos == 6'd63) begin
                hash_chain = sha1_compress(hash_chain, blk_words);
            end
        end
        if (fin) begin
            pos = msg_len[5:0];
            put_msg_byte(pos, PadByte);
            for (wi = int'(pos[5:2]) + 1; wi < 16; wi++) begin
                blk_words[wi] = '0;
            end
            // No room left for the length: it spills into an extra block.
            if (pos >= 6'd56) begin
                hash_chain = sha1_compress(hash_chain, blk_words);
                for (wi = 0; wi < 14; wi++) begin
                    blk_words[wi] = '0;
                end
            end
            bit_len = {msg_len, 3'b000};
            blk_words[14] = bit_len[63:32];
            blk_words[15] = bit_len[31:0];
            hash_chain = sha1_compress(hash_chain, blk_words);
            digest_q.push_back(hash_chain);
            hash_chain = InitChain;
            msg_len = '0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Digest checking
    // ------------------------------------------------------------------
    function automatic void note_error(string msg);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got_digest = {o_digest_word4, o_digest_word3, o_digest_word2,
                          o_digest_word1, o_digest_word0};
            if (digest_q.size() == 0) begin
                note_error($sformatf("cycle %0d: digest %h with no message pending",
                                     cycle_cnt, got_digest));
            end else begin
                want_digest = digest_q.pop_front();
                for (chk_idx = 0; chk_idx < 5; chk_idx++) begin
                    if (got_digest[chk_idx] !== want_digest[chk_idx]) begin
                        note_error($sformatf("cycle %0d: digest word%0d expected %h got %h",
                                             cycle_cnt, chk_idx, want_digest[chk_idx],
                                             got_digest[chk_idx]));
                    end
                end
            end
        end
    end

    // Output side: random stalls, or a solid stall while a hold-off runs.
    always @(posedge i_clk) begin
        if (holdoff_on) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Request driving
    // ------------------------------------------------------------------
    // Entered just after a rising edge; valid stays high after acceptance so
    // back-to-back requests never drop it.
    task automatic send_item(logic [7:0] data, logic has, logic fin);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= data;
        i_has_byte  <= has;
        i_last      <= fin;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        sha1_absorb(data, has, fin);
        if (has || fin) begin
            items_sent++;
        end
    endtask

    // A length of zero always ends with an empty final request.
    task automatic send_message(int unsigned len, bit split_last, int unsigned noise_pct);
        int unsigned i;
        for (i = 0; i < len; i++) begin
            if ($urandom_range(99) < noise_pct) begin
                send_item(8'($urandom), 1'b0, 1'b0);
            end
            send_item(8'($urandom), 1'b1, (i == len - 1) && !split_last);
        end
        if (split_last || len == 0) begin
            send_item(8'($urandom), 1'b0, 1'b1);
        end
    endtask

    function automatic int unsigned pick_msg_len();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 65) begin
            return $urandom_range(16);
        end else if (sel < 90) begin
            return $urandom_range(100, 17);
        end
        // Near the one- and two-block edges, where padding spills over.
        return 64 * $urandom_range(2, 1) + $urandom_range(16) - 8;
    endfunction

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (digest_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed_vectors();
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'hA5, 1'b0, 1'b0);
        send_item(8'h5A, 1'b0, 1'b1);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h7F, 1'b1, 1'b0);
        send_item(8'h01, 1'b1, 1'b0);
        send_item(8'hFE, 1'b1, 1'b0);
        send_item(8'hFF, 1'b0, 1'b1);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hFF, 1'b0, 1'b1);
        wait_drain();
    endtask

    task automatic test_padding_boundaries();
        snd_idle_pct  = 20;
        rcv_stall_pct = 20;
        send_message(55, 1'b0, 0);
        send_message(56, 1'b1, 0);
        send_message(63, 1'b0, 5);
        send_message(64, 1'b1, 0);
        wait_drain();
    endtask

    task automatic test_random_traffic(int unsigned snd_pct, int unsigned rcv_pct);
        int unsigned start;
        snd_idle_pct  = snd_pct;
        rcv_stall_pct = rcv_pct;
        start = items_sent;
        while (items_sent - start < PHASE_ITEMS) begin
            send_message(pick_msg_len(), 1'($urandom_range(1)), 5);
        end
        wait_drain();
    endtask

    // One digest fills the output register, the next blocks the core, and
    // the input must then stall until the hold-off ends.
    task automatic test_output_backpressure();
        int unsigned m;
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        fork
            begin
                @(negedge i_clk);
                holdoff_on = 1'b1;
                repeat (HOLDOFF_LEN) @(negedge i_clk);
                holdoff_on = 1'b0;
            end
        join_none
        for (m = 0; m < 6; m++) begin
            send_message($urandom_range(8, 1), 1'($urandom_range(1)), 0);
        end
        wait_drain();
        send_message(3, 1'b0, 0);
        wait_drain();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_vectors();
        test_padding_boundaries();
        test_random_traffic(0, 0);
        test_random_traffic(58, 0);
        test_random_traffic(0, 58);
        test_random_traffic(13, 13);
        test_output_backpressure();
        if (err_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
